FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge outside reset.
`define KCT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define KCT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/kct_pkg.sv
// Types and constants for the keyed count table.
`timescale 1ns / 1ps

package kct_pkg;

    localparam int KEY_IN_W   = 16;
    localparam int SLOT_IN_W  = 4;
    localparam int AMOUNT_W   = 16;
    localparam int STATUS_W   = 3;
    localparam int COUNT_OUT_W = 16;
    localparam int USED_OUT_W = 5;

    localparam logic [STATUS_W-1:0] ST_MERGED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPENDED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DECREMENTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BADSLOT     = 3'd6;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Action broadcast along the cell row in the update cycle
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_MERGE,
        ACT_APPEND,
        ACT_DECR,
        ACT_SHIFT
    } act_t;

    typedef struct packed {
        act_t                act;
        logic [AMOUNT_W-1:0] amount;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

endpackage

FILE: rtl/kct_in_if.sv
// Request channel: valid/ready with the operation payload.
`timescale 1ns / 1ps

interface kct_in_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [kct_pkg::KEY_IN_W-1:0]   item_key;
    logic [kct_pkg::SLOT_IN_W-1:0]  slot;
    logic [kct_pkg::AMOUNT_W-1:0]   amount;

    modport source (output valid, output operation, output item_key, output slot,
                    output amount, input ready);
    modport sink   (input valid, input operation, input item_key, input slot,
                    input amount, output ready);
endinterface

FILE: rtl/kct_out_if.sv
// Result channel: valid/ready with the status payload.
`timescale 1ns / 1ps

interface kct_out_if;
    logic                             valid;
    logic                             ready;
    logic [kct_pkg::STATUS_W-1:0]     status;
    logic [kct_pkg::SLOT_IN_W-1:0]    affected_slot;
    logic [kct_pkg::COUNT_OUT_W-1:0]  slot_count;
    logic [kct_pkg::USED_OUT_W-1:0]   entries_used;

    modport source (output valid, output status, output affected_slot,
                    output slot_count, output entries_used, input ready);
    modport sink   (input valid, input status, input affected_slot,
                    input slot_count, input entries_used, output ready);
endinterface

FILE: rtl/keyed_count_table_core.sv
// A request is taken only in S_IDLE, so it waits until the last one is applied. The cell row
// compares all keys in the transfer cycle and applies merge, append, decrement or shift-down
// in S_EXEC, loading the result registers in that cycle unless a waiting result stalls it.
// A waiting result does not block the next request; only the update cycle stalls on it.
// Reset clears the entry count, the sequencer and the result valid; keys and counts hold.
`timescale 1ns / 1ps

module keyed_count_table_core #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    kct_in_if.sink    cmd,
    kct_out_if.source res
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > kct_pkg::SLOT_IN_W) ? CNT_W : kct_pkg::SLOT_IN_W;

    kct_pkg::state_t                 state_reg;
    kct_pkg::state_t                 state_next;
    logic [CNT_W-1:0]                used_reg;
    logic [CNT_W-1:0]                used_next;
    logic                            op_reg;
    logic [KEY_BITS-1:0]             key_reg;
    logic [kct_pkg::SLOT_IN_W-1:0]   slot_reg;
    logic [kct_pkg::AMOUNT_W-1:0]    amt_reg;

    logic                            out_valid_reg;
    logic [kct_pkg::STATUS_W-1:0]    status_reg;
    logic [kct_pkg::SLOT_IN_W-1:0]   aslot_reg;
    logic [kct_pkg::COUNT_OUT_W-1:0] scount_reg;
    logic [kct_pkg::USED_OUT_W-1:0]  eused_reg;

    logic                            in_xfer;
    logic                            exec_go;
    logic [KEY_BITS-1:0]             in_key;

    logic [KEY_BITS-1:0]             cell_key   [ENTRIES];
    logic [COUNT_BITS-1:0]           cell_count [ENTRIES];
    logic [COUNT_BITS-1:0]           cell_nxt   [ENTRIES];
    logic [ENTRIES-1:0]              hit;
    logic [ENTRIES-1:0]              gt;
    logic [ENTRIES-1:0]              first_hit;
    logic [IDX_W-1:0]                hit_idx;
    logic [IDX_W-1:0]                slot_idx;
    logic                            gt_at_slot;

    kct_pkg::act_t                   act;
    kct_pkg::cell_cmd_t              cell_cmd;
    logic [IDX_W-1:0]                tgt;
    logic [kct_pkg::STATUS_W-1:0]    status;
    logic                            zero_count;
    logic [COUNT_BITS-1:0]           sel_count;

    assign in_xfer   = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == kct_pkg::S_IDLE);
    assign exec_go   = (state_reg == kct_pkg::S_EXEC) && (!out_valid_reg || res.ready);
    assign in_key    = KEY_BITS'(cmd.item_key);
    assign slot_idx  = IDX_W'(slot_reg);

    assign cell_cmd.act    = exec_go ? act : kct_pkg::ACT_NONE;
    assign cell_cmd.amount = amt_reg;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            logic [KEY_BITS-1:0]   nk;
            logic [COUNT_BITS-1:0] nc;
            if (g < ENTRIES - 1)
            begin : g_mid
                assign nk = cell_key[g+1];
                assign nc = cell_count[g+1];
            end
            else
            begin : g_last
                assign nk = cell_key[g];
                assign nc = cell_count[g];
            end

            kct_cell #(
                .INDEX      (g),
                .IDX_W      (IDX_W),
                .CNT_W      (CNT_W),
                .KEY_BITS   (KEY_BITS),
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .clk        (clk),
                .capture    (in_xfer),
                .in_key     (in_key),
                .used       (used_reg),
                .tgt        (tgt),
                .op_key     (key_reg),
                .cmd        (cell_cmd),
                .next_key   (nk),
                .next_count (nc),
                .key        (cell_key[g]),
                .count      (cell_count[g]),
                .count_nxt  (cell_nxt[g]),
                .hit        (hit[g]),
                .gt         (gt[g])
            );
        end
    endgenerate

    // isolate the lowest matching position
    assign first_hit = hit & (~hit + ENTRIES'(1));

    always_comb
    begin
        hit_idx    = '0;
        gt_at_slot = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (first_hit[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
            if ((IDX_W'(i) == slot_idx) && gt[i])
            begin
                gt_at_slot = 1'b1;
            end
        end
    end

    always_comb
    begin
        act        = kct_pkg::ACT_NONE;
        tgt        = '0;
        status     = kct_pkg::ST_MERGED;
        used_next  = used_reg;
        zero_count = 1'b0;
        if (op_reg == kct_pkg::OP_ADD)
        begin
            if (|hit)
            begin
                act = kct_pkg::ACT_MERGE;
                tgt = hit_idx;
            end
            else if (used_reg == CNT_W'(ENTRIES))
            begin
                status     = kct_pkg::ST_FULL;
                zero_count = 1'b1;
            end
            else
            begin
                act       = kct_pkg::ACT_APPEND;
                tgt       = used_reg[IDX_W-1:0];
                status    = kct_pkg::ST_APPENDED;
                used_next = used_reg + CNT_W'(1);
            end
        end
        else if (used_reg == '0)
        begin
            status     = kct_pkg::ST_EMPTY;
            zero_count = 1'b1;
        end
        else if (CMP_W'(slot_reg) >= CMP_W'(used_reg))
        begin
            status     = kct_pkg::ST_BADSLOT;
            zero_count = 1'b1;
        end
        else if (gt_at_slot)
        begin
            act    = kct_pkg::ACT_DECR;
            tgt    = slot_idx;
            status = kct_pkg::ST_DECREMENTED;
        end
        else
        begin
            act        = kct_pkg::ACT_SHIFT;
            tgt        = slot_idx;
            status     = kct_pkg::ST_DELETED;
            used_next  = used_reg - CNT_W'(1);
            zero_count = 1'b1;
        end
    end

    always_comb
    begin
        sel_count = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (IDX_W'(i) == tgt)
            begin
                sel_count = sel_count | cell_nxt[i];
            end
        end
        if (zero_count)
        begin
            sel_count = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kct_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = kct_pkg::S_EXEC;
                end
            end
            kct_pkg::S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = kct_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kct_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kct_pkg::S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_go)
            begin
                used_reg      <= used_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg   <= cmd.operation;
            key_reg  <= in_key;
            slot_reg <= cmd.slot;
            amt_reg  <= cmd.amount;
        end
        if (exec_go)
        begin
            status_reg <= status;
            aslot_reg  <= kct_pkg::SLOT_IN_W'(tgt);
            scount_reg <= kct_pkg::COUNT_OUT_W'(sel_count);
            eused_reg  <= kct_pkg::USED_OUT_W'(used_next);
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.status        = status_reg;
    assign res.affected_slot = aslot_reg;
    assign res.slot_count    = scount_reg;
    assign res.entries_used  = eused_reg;

endmodule

FILE: rtl/kct_cell.sv
// One table position: key, count, match flag and the update for each action.
`timescale 1ns / 1ps

module kct_cell #(
    parameter int INDEX      = 0,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5,
    parameter int KEY_BITS   = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  capture,
    input  logic [KEY_BITS-1:0]   in_key,
    input  logic [CNT_W-1:0]      used,
    input  logic [IDX_W-1:0]      tgt,
    input  logic [KEY_BITS-1:0]   op_key,
    input  kct_pkg::cell_cmd_t    cmd,
    input  logic [KEY_BITS-1:0]   next_key,
    input  logic [COUNT_BITS-1:0] next_count,
    output logic [KEY_BITS-1:0]   key,
    output logic [COUNT_BITS-1:0] count,
    output logic [COUNT_BITS-1:0] count_nxt,
    output logic                  hit,
    output logic                  gt
);

    localparam int SUM_W = ((COUNT_BITS > kct_pkg::AMOUNT_W) ? COUNT_BITS
                                                             : kct_pkg::AMOUNT_W) + 1;

    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  hit_reg;
    logic                  valid;
    logic                  at_tgt;
    logic                  at_or_above;
    logic [SUM_W-1:0]      count_ext;
    logic [SUM_W-1:0]      amount_ext;
    logic [SUM_W-1:0]      sum;
    logic [COUNT_BITS-1:0] merge_val;
    logic [COUNT_BITS-1:0] append_val;

    assign valid       = CNT_W'(INDEX) < used;
    assign at_tgt      = IDX_W'(INDEX) == tgt;
    assign at_or_above = IDX_W'(INDEX) >= tgt;
    assign count_ext   = SUM_W'(count_reg);
    assign amount_ext  = SUM_W'(cmd.amount);
    assign sum         = count_ext + amount_ext;
    assign merge_val   = (|sum[SUM_W-1:COUNT_BITS]) ? '1 : sum[COUNT_BITS-1:0];
    assign append_val  = (|amount_ext[SUM_W-1:COUNT_BITS]) ? '1
                                                           : amount_ext[COUNT_BITS-1:0];
    assign gt          = count_ext > amount_ext;

    always_comb
    begin
        key_next  = key_reg;
        count_nxt = count_reg;
        case (cmd.act)
            kct_pkg::ACT_MERGE:
            begin
                if (at_tgt)
                begin
                    count_nxt = merge_val;
                end
            end
            kct_pkg::ACT_APPEND:
            begin
                if (at_tgt)
                begin
                    key_next  = op_key;
                    count_nxt = append_val;
                end
            end
            kct_pkg::ACT_DECR:
            begin
                if (at_tgt)
                begin
                    count_nxt = COUNT_BITS'(count_ext - amount_ext);
                end
            end
            kct_pkg::ACT_SHIFT:
            begin
                // take the neighbour's entry to close the gap
                if (at_or_above)
                begin
                    key_next  = next_key;
                    count_nxt = next_count;
                end
            end
            default:
            begin
                key_next  = key_reg;
                count_nxt = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        count_reg <= count_nxt;
        if (capture)
        begin
            hit_reg <= valid && (key_reg == in_key);
        end
    end

    assign key   = key_reg;
    assign count = count_reg;
    assign hit   = hit_reg;

endmodule

FILE: rtl/kct_checker.sv
// Port-level checks for the keyed count table, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kct_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [kct_pkg::STATUS_W-1:0]     status,
    input logic [kct_pkg::SLOT_IN_W-1:0]    affected_slot,
    input logic [kct_pkg::COUNT_OUT_W-1:0]  slot_count,
    input logic [kct_pkg::USED_OUT_W-1:0]   entries_used
);

    // hold a stalled result
    `KCT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status), "result dropped or changed while stalled")

    // one item in flight: a transfer closes the request side
    `KCT_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_valid && in_ready, !in_ready, "request taken while an item is being applied")

    `KCT_ASSERT(a_flag_zero, clk, rst_n, (out_valid && (status == kct_pkg::ST_EMPTY || status == kct_pkg::ST_FULL || status == kct_pkg::ST_BADSLOT)) |-> (affected_slot == '0 && slot_count == '0), "flagged result carries a slot or count")

    `KCT_ASSERT(a_empty_used, clk, rst_n, (out_valid && status == kct_pkg::ST_EMPTY) |-> (entries_used == '0), "empty status with entries in use")

    `KCT_ASSERT(a_delete_zero, clk, rst_n, (out_valid && status == kct_pkg::ST_DELETED) |-> (slot_count == '0), "deleted entry reports a count")

endmodule

bind keyed_count_table_core kct_checker u_kct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (cmd.valid),
    .in_ready      (cmd.ready),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .status        (res.status),
    .affected_slot (res.affected_slot),
    .slot_count    (res.slot_count),
    .entries_used  (res.entries_used)
);
